>>> hw/rtl/array_list_table_engine_defines.svh
// assertion helpers for the array list table engine
// both expect clk and rst to be visible in the module that uses them
`ifndef ARRAY_LIST_TABLE_ENGINE_DEFINES_SVH
`define ARRAY_LIST_TABLE_ENGINE_DEFINES_SVH

// same-cycle implication
`define ALC_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ALC_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/alc_pkg.sv
package alc_pkg;

  localparam int CAPACITY = 64;
  localparam int WORD_W   = 32;
  localparam int POS_W    = 6;
  localparam int CNT_W    = 7;
  localparam int OP_W     = 3;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT_AT      = 3'd0,
    OP_DELETE_AT      = 3'd1,
    OP_ORDERED_INSERT = 3'd2,
    OP_REVERSE        = 3'd3,
    OP_CLEAR          = 3'd4,
    OP_READ_AT        = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL,
    CELL_ORD_CMP,
    CELL_ORD_SHIFT,
    CELL_MIRROR,
    CELL_SHIFT_DN
  } cell_op_t;

  // broadcast to every cell of the row
  typedef struct packed {
    cell_op_t                  op;
    logic [POS_W-1:0]          pos;
    logic [CNT_W-1:0]          count;
    logic signed [WORD_W-1:0]  val;
  } cell_ctrl_t;

endpackage

>>> hw/rtl/alc_if.sv
interface alc_cmd_if;
  logic                               valid;
  logic                               ready;
  logic [alc_pkg::OP_W-1:0]           opcode;
  logic [alc_pkg::POS_W-1:0]          position;
  logic signed [alc_pkg::WORD_W-1:0]  item_value;

  modport source (output valid, opcode, position, item_value, input ready);
  modport sink   (input valid, opcode, position, item_value, output ready);
endinterface

interface alc_rsp_if;
  logic                               valid;
  logic                               ready;
  logic                               status;
  logic signed [alc_pkg::WORD_W-1:0]  result_value;
  logic [alc_pkg::CNT_W-1:0]          element_count;

  modport source (output valid, status, result_value, element_count, input ready);
  modport sink   (input valid, status, result_value, element_count, output ready);
endinterface

>>> hw/rtl/alc_cell.sv
module alc_cell (
  input  logic                               clk,
  input  alc_pkg::cell_ctrl_t                ctrl,
  input  logic [alc_pkg::POS_W-1:0]          idx,
  input  logic signed [alc_pkg::WORD_W-1:0]  left_word,
  input  logic signed [alc_pkg::WORD_W-1:0]  right_word,
  input  logic signed [alc_pkg::WORD_W-1:0]  mirror_word,
  input  logic                               s_in,
  input  logic                               below_s,
  output logic signed [alc_pkg::WORD_W-1:0]  word,
  output logic                               s_out,
  output logic signed [alc_pkg::WORD_W-1:0]  sel_word
);

  logic signed [alc_pkg::WORD_W-1:0] word_next;
  logic                              ge;
  logic                              ge_next;
  logic [alc_pkg::CNT_W-1:0]         idx_cnt;
  logic                              live;
  logic                              in_span;

  assign idx_cnt = alc_pkg::CNT_W'(idx);
  assign live    = idx_cnt < ctrl.count;
  assign in_span = idx_cnt <= ctrl.count;

  // high when this word and every live word above it are not below the new value
  assign s_out    = !live || (ge && s_in);
  assign sel_word = (idx == ctrl.pos) ? word : '0;

  always_comb begin
    word_next = word;
    ge_next   = ge;
    unique case (ctrl.op)
      alc_pkg::CELL_HOLD: ;
      alc_pkg::CELL_INS: begin
        if (idx > ctrl.pos) begin
          word_next = left_word;
        end else if (idx == ctrl.pos) begin
          word_next = ctrl.val;
        end
      end
      alc_pkg::CELL_DEL: begin
        if (idx >= ctrl.pos) begin
          word_next = right_word;
        end
      end
      alc_pkg::CELL_ORD_CMP: begin
        ge_next = !(word < ctrl.val);
      end
      alc_pkg::CELL_ORD_SHIFT: begin
        if (in_span) begin
          if (below_s) begin
            word_next = left_word;
          end else if (s_out) begin
            word_next = ctrl.val;
          end
        end
      end
      alc_pkg::CELL_MIRROR:   word_next = mirror_word;
      alc_pkg::CELL_SHIFT_DN: word_next = right_word;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    word <= word_next;
    ge   <= ge_next;
  end

endmodule

>>> hw/rtl/array_list_table_engine.sv
// channel  dir  payload                                      handshake
// cmd      in   opcode, position, item_value                 valid/ready
// rsp      out  status, result_value, element_count          valid/ready
//
// insert_at, delete_at, clear, read_at, unused opcodes and errors: result registered when the command is taken
// ordered_insert: a compare in every cell, then the shift along the row
// reverse: a mirror swap, then one cell step per cycle; a full row needs only the swap
// one command at a time; cmd is taken while idle and the result slot is empty or draining
// rst clears the count, the sequencer and the result slot; the word cells keep their data
`include "array_list_table_engine_defines.svh"

module array_list_table_engine (
  input  logic            clk,
  input  logic            rst,
  alc_cmd_if.sink         cmd,
  alc_rsp_if.source       rsp
);

  localparam logic [alc_pkg::CNT_W-1:0] CAP_CNT = alc_pkg::CNT_W'(alc_pkg::CAPACITY);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ORD,
    S_REV
  } state_t;

  state_t                             state;
  state_t                             state_next;
  logic [alc_pkg::CNT_W-1:0]          count;
  logic [alc_pkg::CNT_W-1:0]          count_next;
  logic [alc_pkg::CNT_W-1:0]          rev_left;
  logic [alc_pkg::CNT_W-1:0]          rev_left_next;
  logic signed [alc_pkg::WORD_W-1:0]  ord_val;
  logic signed [alc_pkg::WORD_W-1:0]  ord_val_next;

  logic                               acc;
  logic                               out_load;
  logic                               out_status;
  logic signed [alc_pkg::WORD_W-1:0]  out_res;
  logic [alc_pkg::CNT_W-1:0]          pos_cnt;
  logic                               ins_err;
  alc_pkg::cell_ctrl_t                ctrl;

  logic signed [alc_pkg::WORD_W-1:0]  cell_word [alc_pkg::CAPACITY];
  logic signed [alc_pkg::WORD_W-1:0]  cell_sel  [alc_pkg::CAPACITY];
  logic                               cell_s    [alc_pkg::CAPACITY];
  logic signed [alc_pkg::WORD_W-1:0]  rd_word;

  assign cmd.ready = (state == S_IDLE) && (!rsp.valid || rsp.ready);
  assign acc       = cmd.valid && cmd.ready;
  assign pos_cnt   = alc_pkg::CNT_W'(cmd.position);
  assign ins_err   = (count >= CAP_CNT) || (pos_cnt > count);

  for (genvar i = 0; i < alc_pkg::CAPACITY; i++) begin : g_cell
    logic signed [alc_pkg::WORD_W-1:0] left_w;
    logic signed [alc_pkg::WORD_W-1:0] right_w;
    logic                              s_above;
    logic                              s_below;

    if (i == 0) begin : g_bot
      assign left_w  = '0;
      assign s_below = 1'b0;
    end else begin : g_mid_lo
      assign left_w  = cell_word[i-1];
      assign s_below = cell_s[i-1];
    end

    if (i == alc_pkg::CAPACITY - 1) begin : g_top
      assign right_w = '0;
      assign s_above = 1'b1;
    end else begin : g_mid_hi
      assign right_w = cell_word[i+1];
      assign s_above = cell_s[i+1];
    end

    alc_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .idx         (alc_pkg::POS_W'(i)),
      .left_word   (left_w),
      .right_word  (right_w),
      .mirror_word (cell_word[alc_pkg::CAPACITY-1-i]),
      .s_in        (s_above),
      .below_s     (s_below),
      .word        (cell_word[i]),
      .s_out       (cell_s[i]),
      .sel_word    (cell_sel[i])
    );
  end

  // each cell passes its word only when it sits at the requested position
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < alc_pkg::CAPACITY; i++) begin
      rd_word = rd_word | cell_sel[i];
    end
  end

  always_comb begin
    state_next    = state;
    count_next    = count;
    rev_left_next = rev_left;
    ord_val_next  = ord_val;
    out_load      = 1'b0;
    out_status    = 1'b0;
    out_res       = '0;
    ctrl.op       = alc_pkg::CELL_HOLD;
    ctrl.pos      = cmd.position;
    ctrl.count    = count;
    ctrl.val      = cmd.item_value;

    unique case (state)
      S_IDLE: begin
        if (acc) begin
          unique case (alc_pkg::op_t'(cmd.opcode))
            alc_pkg::OP_INSERT_AT: begin
              out_load = 1'b1;
              if (ins_err) begin
                out_status = 1'b1;
              end else begin
                ctrl.op    = alc_pkg::CELL_INS;
                count_next = count + alc_pkg::CNT_W'(1);
              end
            end
            alc_pkg::OP_DELETE_AT: begin
              out_load = 1'b1;
              if (pos_cnt >= count) begin
                out_status = 1'b1;
              end else begin
                ctrl.op    = alc_pkg::CELL_DEL;
                out_res    = rd_word;
                count_next = count - alc_pkg::CNT_W'(1);
              end
            end
            alc_pkg::OP_ORDERED_INSERT: begin
              if (count >= CAP_CNT) begin
                out_load   = 1'b1;
                out_status = 1'b1;
              end else begin
                ctrl.op      = alc_pkg::CELL_ORD_CMP;
                ord_val_next = cmd.item_value;
                state_next   = S_ORD;
              end
            end
            alc_pkg::OP_REVERSE: begin
              if (count == '0) begin
                out_load   = 1'b1;
                out_status = 1'b1;
              end else begin
                // full-row mirror puts the live words at the top, then walk them down
                ctrl.op       = alc_pkg::CELL_MIRROR;
                rev_left_next = CAP_CNT - count;
                if (CAP_CNT == count) begin
                  out_load = 1'b1;
                end else begin
                  state_next = S_REV;
                end
              end
            end
            alc_pkg::OP_CLEAR: begin
              out_load   = 1'b1;
              count_next = '0;
            end
            alc_pkg::OP_READ_AT: begin
              out_load = 1'b1;
              if (pos_cnt >= count) begin
                out_status = 1'b1;
              end else begin
                out_res = rd_word;
              end
            end
            default: begin
              out_load   = 1'b1;
              out_status = 1'b1;
            end
          endcase
        end
      end
      S_ORD: begin
        ctrl.op    = alc_pkg::CELL_ORD_SHIFT;
        ctrl.val   = ord_val;
        count_next = count + alc_pkg::CNT_W'(1);
        out_load   = 1'b1;
        state_next = S_IDLE;
      end
      S_REV: begin
        ctrl.op       = alc_pkg::CELL_SHIFT_DN;
        rev_left_next = rev_left - alc_pkg::CNT_W'(1);
        if (rev_left == alc_pkg::CNT_W'(1)) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (out_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
    rev_left <= rev_left_next;
    ord_val  <= ord_val_next;
    if (out_load) begin
      rsp.status        <= out_status;
      rsp.result_value  <= out_res;
      rsp.element_count <= count_next;
    end
  end

  `ALC_ASSERT_IMP(a_count_cap, 1'b1, count <= CAP_CNT, "element count above capacity")
  `ALC_ASSERT_NXT(a_clear_empties, acc && (cmd.opcode == alc_pkg::OP_CLEAR), count == '0, "clear left live elements")
  `ALC_ASSERT_NXT(a_insert_grows, acc && (cmd.opcode == alc_pkg::OP_INSERT_AT) && !ins_err, count == $past(count) + alc_pkg::CNT_W'(1), "insert did not grow the list")
  `ALC_ASSERT_IMP(a_rev_slot_free, (state == S_REV) || (state == S_ORD), !rsp.valid, "result slot busy during a multi-cycle transaction")
  `ALC_ASSERT_IMP(a_rsp_count, rsp.valid, rsp.element_count == count, "reported count differs from live count")

endmodule
